### hdl/stc_pkg.sv
// Shared types and constants for the sleep tick compensator.
// No dependencies; used by stc_ctrl, stc_dp and sleep_tick_compensator.
package stc_pkg;

    localparam int TPS_W   = 14;
    localparam int HZ_W    = 20;
    localparam int MPT_W   = 10;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 2;
    localparam int SUM_W   = 64;
    localparam int TICK_W  = 32;
    localparam int STEP_W  = 6;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(TPS_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] REQ_STEPS = STEP_W'(TICK_W);

    localparam logic [IDX_W-1:0] CFG_TPS   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_HZ    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MPT   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_CLAMP = 2'd3;

    localparam logic [TPS_W-1:0] TPS_RESET = 14'd1000;
    localparam logic [HZ_W-1:0]  HZ_RESET  = 20'd32768;
    localparam logic [MPT_W-1:0] MPT_RESET = 10'd1;

    typedef struct packed {
        logic load_entry;
        logic start;
        logic mul_step;
        logic div_step;
        logic req_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

### hdl/stc_ctrl.sv
// Sequencer for the sleep tick compensator: accept, multiply, divide, deliver.
// Depends on stc_pkg.
module stc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_operation,
    output logic          o_ready,
    input  stc_pkg::t_sts i_sts,
    output stc_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [stc_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic                        w_acc;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_entry = w_acc && !i_operation;
                o_cmd.start      = w_acc && i_operation;
                if (w_acc && i_operation) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == stc_pkg::MUL_LAST) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.req_step = (r_cnt < stc_pkg::REQ_STEPS);
                if (r_cnt == stc_pkg::DIV_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### hdl/stc_dp.sv
// Datapath: config registers, shift-add multiplier, restoring dividers, result register.
// Depends on stc_pkg; driven by stc_ctrl commands.
module stc_dp #(
    parameter int COUNTER_WIDTH = 64,
    parameter int CARRY_WIDTH   = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [stc_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [stc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [COUNTER_WIDTH-1:0]    i_counter_value,
    input  logic [stc_pkg::TICK_W-1:0]  i_sleep_ms,
    input  stc_pkg::t_cmd               i_cmd,
    output stc_pkg::t_sts               o_sts,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [stc_pkg::TICK_W-1:0]  o_credit_ticks,
    output logic [stc_pkg::TICK_W-1:0]  o_requested_ticks,
    output logic                        o_was_clamped
);

    logic [stc_pkg::TPS_W-1:0]  r_tps;
    logic [stc_pkg::HZ_W-1:0]   r_hz;
    logic [stc_pkg::MPT_W-1:0]  r_mpt;
    logic                       r_clamp;

    logic [COUNTER_WIDTH-1:0]   r_entry;
    logic [CARRY_WIDTH-1:0]     r_carry;

    logic [stc_pkg::SUM_W-1:0]  r_acc;
    logic [stc_pkg::SUM_W-1:0]  r_mcand;
    logic [stc_pkg::TPS_W-1:0]  r_mplier;
    logic [stc_pkg::HZ_W-1:0]   r_rem;
    logic [stc_pkg::TICK_W-1:0] r_ms;
    logic [stc_pkg::TICK_W-1:0] r_rq;
    logic [stc_pkg::MPT_W-1:0]  r_rr;
    logic                       r_out_valid;

    logic [stc_pkg::HZ_W-1:0]   w_hz;
    logic [stc_pkg::MPT_W-1:0]  w_mpt;
    logic [COUNTER_WIDTH-1:0]   w_elapsed;
    logic [stc_pkg::HZ_W:0]     w_dt;
    logic                       w_dge;
    logic [stc_pkg::MPT_W:0]    w_rt;
    logic                       w_rge;
    logic [stc_pkg::TICK_W-1:0] w_actual;
    logic [stc_pkg::TICK_W-1:0] w_req;

    assign w_hz      = (r_hz == '0) ? stc_pkg::HZ_W'(1) : r_hz;
    assign w_mpt     = (r_mpt == '0) ? stc_pkg::MPT_W'(1) : r_mpt;
    assign w_elapsed = i_counter_value - r_entry;

    assign w_dt  = {r_rem, r_acc[stc_pkg::SUM_W-1]};
    assign w_dge = (w_dt >= {1'b0, w_hz});
    assign w_rt  = {r_rr, r_rq[stc_pkg::TICK_W-1]};
    assign w_rge = (w_rt >= {1'b0, w_mpt});

    assign w_actual = r_acc[stc_pkg::TICK_W-1:0];
    assign w_req    = (w_mpt == stc_pkg::MPT_W'(1)) ? (r_ms - 1'b1) : r_rq;

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= stc_pkg::TPS_RESET;
            r_hz        <= stc_pkg::HZ_RESET;
            r_mpt       <= stc_pkg::MPT_RESET;
            r_clamp     <= 1'b1;
            r_entry     <= '0;
            r_carry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    stc_pkg::CFG_TPS:   r_tps   <= i_cfg_data[stc_pkg::TPS_W-1:0];
                    stc_pkg::CFG_HZ:    r_hz    <= i_cfg_data[stc_pkg::HZ_W-1:0];
                    stc_pkg::CFG_MPT:   r_mpt   <= i_cfg_data[stc_pkg::MPT_W-1:0];
                    stc_pkg::CFG_CLAMP: r_clamp <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load_entry) begin
                r_entry <= i_counter_value;
            end
            if (i_cmd.finish) begin
                r_carry     <= CARRY_WIDTH'(r_rem);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc    <= stc_pkg::SUM_W'(r_carry);
            r_mcand  <= stc_pkg::SUM_W'(w_elapsed);
            r_mplier <= r_tps;
            r_rem    <= '0;
            r_ms     <= i_sleep_ms;
            r_rq     <= i_sleep_ms + stc_pkg::TICK_W'(w_mpt >> 1);
            r_rr     <= '0;
        end
        if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_dge ? stc_pkg::HZ_W'(w_dt - {1'b0, w_hz})
                           : w_dt[stc_pkg::HZ_W-1:0];
            r_acc <= {r_acc[stc_pkg::SUM_W-2:0], w_dge};
        end
        if (i_cmd.req_step) begin
            r_rr <= w_rge ? stc_pkg::MPT_W'(w_rt - {1'b0, w_mpt})
                          : w_rt[stc_pkg::MPT_W-1:0];
            r_rq <= {r_rq[stc_pkg::TICK_W-2:0], w_rge};
        end
        if (i_cmd.finish) begin
            o_requested_ticks <= w_req;
            if (r_clamp && (w_actual > w_req)) begin
                o_credit_ticks <= w_req;
                o_was_clamped  <= 1'b1;
            end else begin
                o_credit_ticks <= w_actual;
                o_was_clamped  <= 1'b0;
            end
        end
    end

endmodule

### hdl/sleep_tick_compensator.sv
// Sleep tick compensator top level: joins stc_ctrl and stc_dp. Depends on stc_pkg.
// Entry word: latches the counter value, no result. Exit word: after accept, 14 shift-add
// multiply steps over the tick rate, 64 restoring divide steps by the slow clock and
// 1 deliver step register the result; the next word is taken after deliver; one exit in flight.
// Input is taken again while a result waits; deliver holds until that result is taken.
// Sync active-low reset clears control, entry count, carried remainder, restores config.
module sleep_tick_compensator #(
    parameter int COUNTER_WIDTH = 64,
    parameter int CARRY_WIDTH   = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [stc_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [stc_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_operation,
    input  logic [COUNTER_WIDTH-1:0]    i_counter_value,
    input  logic [stc_pkg::TICK_W-1:0]  i_sleep_ms,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [stc_pkg::TICK_W-1:0]  o_credit_ticks,
    output logic [stc_pkg::TICK_W-1:0]  o_requested_ticks,
    output logic                        o_was_clamped
);

    stc_pkg::t_cmd w_cmd;
    stc_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    stc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_ready     (o_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    stc_dp #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .CARRY_WIDTH   (CARRY_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_counter_value   (i_counter_value),
        .i_sleep_ms        (i_sleep_ms),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_credit_ticks    (o_credit_ticks),
        .o_requested_ticks (o_requested_ticks),
        .o_was_clamped     (o_was_clamped)
    );

    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_operation) |=> !o_ready)
        else $error("exit word did not make the block busy");

    a_clamp_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_clamped) |-> (o_credit_ticks == o_requested_ticks))
        else $error("clamped credit differs from requested ticks");

    a_rise_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.finish))
        else $error("result appeared without a finish step");

endmodule
